// ----- rtl/circular_window_line_table_macros.svh -----
// Assertion macros shared by the span table RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef CIRCULAR_WINDOW_LINE_TABLE_MACROS_SVH
`define CIRCULAR_WINDOW_LINE_TABLE_MACROS_SVH

// Same-cycle implication.
`define CWLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CWLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cwlt_pkg.sv -----
// Shared constants, types and the column clamp for the circle span table.
// No dependencies.
package cwlt_pkg;

    localparam int ROWS      = 160;                 // visible scanlines
    localparam int COLS      = 240;                 // visible columns
    localparam int DEPTH     = ROWS + 1;            // extra row mirrors row 0
    localparam int ROW_AW    = $clog2(DEPTH);
    localparam int COL_W     = 8;                   // edge field width
    localparam int DATA_W    = 2 * COL_W;           // {left, right}
    localparam int ROW_IDX_W = 8;                   // row_index field width
    localparam int CRD_W     = 10;                  // center field width
    localparam int RAD_W     = 9;                   // radius field width

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              re;
        logic [ROW_AW-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic                   go_draw;
        logic                   go_read;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic [RAD_W-1:0]       radius;
        logic [ROW_IDX_W-1:0]   row;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic rd_done;     // RAM read data valid for the pending read
        logic rd_zero;     // row past the table: result is zero
    } t_seq_stat;

    // Clamp a signed column to [0, COLS-1].
    function automatic logic [COL_W-1:0] clamp_col(input logic signed [11:0] c);
        logic [COL_W-1:0] res;
        if (c < 12'sd0) begin
            res = '0;
        end else if (c >= $signed(12'(COLS))) begin
            res = COL_W'(COLS - 1);
        end else begin
            res = c[COL_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/cwlt_ram.sv -----
// Span table storage: one write port, one read port, registered read data.
// Depends on cwlt_pkg.
module cwlt_ram
    import cwlt_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/cwlt_seq.sv -----
// Sequencer: table clear, midpoint circle walk, row 0 copy and read issue.
// Depends on cwlt_pkg and the assertion macros; drives the cwlt_ram port.
`include "circular_window_line_table_macros.svh"

module cwlt_seq
    import cwlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_rd_data,
    output t_mem_req          o_req,
    output t_seq_stat         o_stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_W0    = 4'd2;  // row cy-x, span +-y
    localparam logic [3:0] S_W1    = 4'd3;  // row cy+x, span +-y
    localparam logic [3:0] S_W2    = 4'd4;  // row cy-y, span +-x
    localparam logic [3:0] S_W3    = 4'd5;  // row cy+y, span +-x, step
    localparam logic [3:0] S_CPRD  = 4'd6;
    localparam logic [3:0] S_CPWR  = 4'd7;
    localparam logic [3:0] S_RDOUT = 4'd8;

    logic [3:0]              r_state, n_state;
    logic [ROW_AW-1:0]       r_clr,   n_clr;
    logic                    r_draw,  n_draw;
    logic                    r_zero,  n_zero;
    logic signed [CRD_W-1:0] r_cx,    n_cx;
    logic signed [CRD_W-1:0] r_cy,    n_cy;
    logic signed [10:0]      r_x,     n_x;
    logic signed [10:0]      r_y,     n_y;
    logic signed [12:0]      r_d,     n_d;

    logic               side_x;     // rows at cy+-x use the span +-y
    logic signed [11:0] off, side, cx_e, cy_e, row;
    logic               row_ok;
    logic [DATA_W-1:0]  span;
    logic signed [12:0] two_x3, two_ym1;
    logic signed [10:0] ym1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;   // table comes up cleared
            r_clr   <= '0;
            r_draw  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_draw  <= n_draw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= n_zero;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_x    <= n_x;
        r_y    <= n_y;
        r_d    <= n_d;
    end

    // Shared row / span datapath for the four write steps.
    always_comb begin
        side_x  = (r_state == S_W0) || (r_state == S_W1);
        cx_e    = {{2{r_cx[CRD_W-1]}}, r_cx};
        cy_e    = {{2{r_cy[CRD_W-1]}}, r_cy};
        off     = side_x ? {r_x[10], r_x} : {r_y[10], r_y};
        side    = side_x ? {r_y[10], r_y} : {r_x[10], r_x};
        row     = ((r_state == S_W0) || (r_state == S_W2)) ? cy_e - off : cy_e + off;
        row_ok  = !row[11] && (row[10:0] < 11'(ROWS));
        span    = {clamp_col(cx_e - side), clamp_col(cx_e + side)};
        two_x3  = {r_x[10], r_x, 1'b0} + 13'sd3;
        ym1     = r_y - 11'sd1;
        two_ym1 = {ym1[10], ym1, 1'b0};
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_draw  = r_draw;
        n_zero  = r_zero;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_x     = r_x;
        n_y     = r_y;
        n_d     = r_d;
        o_req   = '0;
        o_stat.busy    = (r_state != S_IDLE);
        o_stat.rd_done = 1'b0;
        o_stat.rd_zero = r_zero;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.go_draw) begin
                    n_cx    = i_cmd.cx;
                    n_cy    = i_cmd.cy;
                    n_x     = '0;
                    n_y     = {2'b00, i_cmd.radius};
                    n_d     = 13'sd1 - $signed({4'b0000, i_cmd.radius});
                    n_clr   = '0;
                    n_draw  = 1'b1;
                    n_state = S_CLR;
                end else if (i_cmd.go_read) begin
                    o_req.re      = 1'b1;
                    o_req.rd_addr = i_cmd.row[ROW_AW-1:0];
                    n_zero        = (i_cmd.row > ROW_IDX_W'(ROWS));
                    n_state       = S_RDOUT;
                end
            end
            S_RDOUT: begin
                o_stat.rd_done = 1'b1;
                n_state        = S_IDLE;
            end
            S_CLR: begin
                o_req.we      = 1'b1;
                o_req.wr_addr = r_clr;
                o_req.wr_data = '0;
                if (r_clr == ROW_AW'(ROWS)) begin
                    n_state = r_draw ? S_W0 : S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_W0: begin
                if (r_y >= r_x) begin
                    o_req.we      = row_ok;
                    o_req.wr_addr = row[ROW_AW-1:0];
                    o_req.wr_data = span;
                    n_state       = S_W1;
                end else begin
                    n_state = S_CPRD;
                end
            end
            S_W1: begin
                o_req.we      = row_ok;
                o_req.wr_addr = row[ROW_AW-1:0];
                o_req.wr_data = span;
                if (r_d >= 13'sd0) begin
                    n_state = S_W2;
                end else begin
                    n_d     = r_d + two_x3;
                    n_x     = r_x + 11'sd1;
                    n_state = S_W0;
                end
            end
            S_W2: begin
                o_req.we      = row_ok;
                o_req.wr_addr = row[ROW_AW-1:0];
                o_req.wr_data = span;
                n_state       = S_W3;
            end
            S_W3: begin
                o_req.we      = row_ok;
                o_req.wr_addr = row[ROW_AW-1:0];
                o_req.wr_data = span;
                n_y           = ym1;
                n_d           = r_d - two_ym1 + two_x3;
                n_x           = r_x + 11'sd1;
                n_state       = S_W0;
            end
            S_CPRD: begin
                o_req.re      = 1'b1;
                o_req.rd_addr = '0;
                n_state       = S_CPWR;
            end
            S_CPWR: begin
                o_req.we      = 1'b1;
                o_req.wr_addr = ROW_AW'(ROWS);
                o_req.wr_data = i_rd_data;
                n_draw        = 1'b0;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CWLT_ASSERT_NOW(a_wr_addr_in_table, o_req.we, o_req.wr_addr <= ROW_AW'(ROWS), "write past table")
    `CWLT_ASSERT_NEXT(a_rd_done_pulse, o_stat.rd_done, !o_stat.rd_done, "read completion repeated")

endmodule

// ----- rtl/circular_window_line_table.sv -----
// Top level of the circle span table: request handshake, result register,
// sequencer and table RAM. Depends on cwlt_pkg, cwlt_seq, cwlt_ram, macros.
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_opcode i_center_x i_center_y
//                                            i_radius i_row_index
//  result    out        o_valid / i_stall    o_right_edge o_left_edge
//
// Read request: one RAM read, then one result into the output register.
// Draw request: a clear of all ROWS+1 rows, then a midpoint walk over roughly
// 0.71*radius+1 steps of x, then the end test and the row 0 copy; the single
// write port of the table RAM serializes the row writes.
// After reset a clearing pass over ROWS+1 = 161 rows runs before the first
// request is taken. A draw is taken while a result waits; a read waits until
// the output register is free.
`include "circular_window_line_table_macros.svh"

module circular_window_line_table
    import cwlt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_opcode,
    input  logic signed [CRD_W-1:0] i_center_x,
    input  logic signed [CRD_W-1:0] i_center_y,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic [ROW_IDX_W-1:0]    i_row_index,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [COL_W-1:0]        o_right_edge,
    output logic [COL_W-1:0]        o_left_edge
);

    t_cmd              cmd;
    t_mem_req          mem_req;
    t_seq_stat         stat;
    logic [DATA_W-1:0] rd_data;
    logic              req_take;

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data,  n_out_data;

    // Busy sequencer holds off everything; a read also needs a free result slot.
    assign o_stall  = stat.busy || (r_out_valid && (i_opcode == OP_READ));
    assign req_take = i_valid && !o_stall;

    always_comb begin
        cmd.go_draw = req_take && (i_opcode == OP_DRAW);
        cmd.go_read = req_take && (i_opcode == OP_READ);
        cmd.cx      = i_center_x;
        cmd.cy      = i_center_y;
        cmd.radius  = i_radius;
        cmd.row     = i_row_index;
    end

    cwlt_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rd_data (rd_data),
        .o_req     (mem_req),
        .o_stat    (stat)
    );

    cwlt_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Result register: loaded when the RAM word lands, freed when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (stat.rd_done) begin
            n_out_valid = 1'b1;
            n_out_data  = stat.rd_zero ? '0 : rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_valid      = r_out_valid;
    assign o_right_edge = r_out_data[COL_W-1:0];
    assign o_left_edge  = r_out_data[DATA_W-1:COL_W];

    `CWLT_ASSERT_NOW(a_no_result_overrun, stat.rd_done, !r_out_valid, "result register overrun")
    `CWLT_ASSERT_NEXT(a_busy_after_take, req_take, stat.busy, "request taken but sequencer idle")

endmodule

// ----- verif/circular_window_line_table_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circular_window_line_table: circle draws and row reads
// checked against an in-bench span table predictor. Depends on cwlt_pkg and the DUT.
module circular_window_line_table_tb;
    import cwlt_pkg::*;

    // Longest correct quiet spell is a radius-511 draw.
    // The watchdog allows many times that.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 2000;
    localparam int ITEM_TARGET    = 800;
    localparam int STEADY_ITEMS   = 180;

    typedef struct {
        logic [COL_W-1:0] right_edge;
        logic [COL_W-1:0] left_edge;
    } t_span;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic                    i_opcode    = OP_READ;
    logic signed [CRD_W-1:0] i_center_x  = '0;
    logic signed [CRD_W-1:0] i_center_y  = '0;
    logic [RAD_W-1:0]        i_radius    = '0;
    logic [ROW_IDX_W-1:0]    i_row_index = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic [COL_W-1:0]        o_right_edge;
    logic [COL_W-1:0]        o_left_edge;

    // Predicted table contents and the read results still owed by the DUT.
    logic [DATA_W-1:0] window_rows [DEPTH];
    t_span             pending_spans [$];

    int error_count  = 0;
    int sent_count   = 0;
    int quiet_cycles = 0;
    int idle_pct     = 11;     // per-cycle idle chance, both sides
    int frame_cx     = 0;
    int frame_cy     = 0;
    int frame_r      = 0;

    circular_window_line_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_row_index  (i_row_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_right_edge (o_right_edge),
        .o_left_edge  (o_left_edge)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Table is all zero out of reset.
    initial begin
        foreach (window_rows[i]) window_rows[i] = '0;
    end

    // ---------------------------------------------------------------- predictor

    // Half-open clamp: negative goes to 0, COLS and above go to COLS-1.
    function automatic logic [COL_W-1:0] edge_limit(input int c);
        if (c < 0) return '0;
        if (c >= COLS) return COL_W'(COLS - 1);
        return COL_W'(c);
    endfunction

    function automatic logic [DATA_W-1:0] span_word(input int left, input int right);
        return {edge_limit(left), edge_limit(right)};
    endfunction

    // Rows off the visible screen are dropped.
    function automatic void put_row(input int row, input logic [DATA_W-1:0] w);
        if (row >= 0 && row < ROWS) window_rows[row] = w;
    endfunction

    // Midpoint walk over one octant; side rows first, then top/bottom rows
    // when the decision steps y, so the later write wins on a shared row.
    function automatic void paint_circle(input int cx, input int cy, input int r);
        int x;
        int y;
        int d;
        logic [DATA_W-1:0] w;
        foreach (window_rows[i]) window_rows[i] = '0;
        x = 0;
        y = r;
        d = 1 - r;
        while (y >= x) begin
            w = span_word(cx - y, cx + y);
            put_row(cy - x, w);
            put_row(cy + x, w);
            if (d >= 0) begin
                w = span_word(cx - x, cx + x);
                put_row(cy - y, w);
                put_row(cy + y, w);
                y--;
                d -= 2 * y;
            end
            d += 2 * x + 3;
            x++;
        end
        window_rows[ROWS] = window_rows[0];
    endfunction

    // Rows past the mirror row read back as zero.
    function automatic t_span lookup_span(input int row);
        logic [DATA_W-1:0] w;
        t_span s;
        w = (row <= ROWS) ? window_rows[row] : '0;
        s.right_edge = w[COL_W-1:0];
        s.left_edge  = w[DATA_W-1:COL_W];
        return s;
    endfunction

    // ---------------------------------------------------------------- request side

    // Drive one request, hold it through any stall, then update the prediction.
    task automatic send_req(input logic op, input int cx, input int cy, input int r,
                            input int row);
        logic signed [CRD_W-1:0] cx_b;
        logic signed [CRD_W-1:0] cy_b;
        logic [RAD_W-1:0]        r_b;
        logic [ROW_IDX_W-1:0]    row_b;
        cx_b  = CRD_W'(cx);
        cy_b  = CRD_W'(cy);
        r_b   = RAD_W'(r);
        row_b = ROW_IDX_W'(row);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_center_x  <= cx_b;
        i_center_y  <= cy_b;
        i_radius    <= r_b;
        i_row_index <= row_b;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (op == OP_DRAW) begin
            paint_circle(int'(cx_b), int'(cy_b), int'(r_b));
        end else begin
            pending_spans.push_back(lookup_span(int'(row_b)));
        end
    endtask

    // Unused fields of a request carry random bits.
    task automatic draw_req(input int cx, input int cy, input int r);
        send_req(OP_DRAW, cx, cy, r, $urandom_range(255));
    endtask

    task automatic read_req(input int row);
        send_req(OP_READ, $urandom, $urandom, $urandom, row);
    endtask

    // Sender holds off until every read result is back.
    task automatic pause_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_spans.size() != 0);
    endtask

    // ---------------------------------------------------------------- result side

    task automatic report_mismatch(input string what, input logic [COL_W-1:0] got,
                                   input logic [COL_W-1:0] want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < idle_pct);
    end

    // Result check plus the no-progress watchdog.
    always @(posedge i_clk) begin : result_check
        t_span want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_spans.size() == 0) begin
                    report_mismatch("result with no read pending", o_right_edge, '0);
                end else begin
                    want = pending_spans.pop_front();
                    if (o_right_edge !== want.right_edge)
                        report_mismatch("right_edge", o_right_edge, want.right_edge);
                    if (o_left_edge !== want.left_edge)
                        report_mismatch("left_edge", o_left_edge, want.left_edge);
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or result moved in %0d cycles", quiet_cycles);
                $display("circular_window_line_table_tb failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- directed tests

    // Table is clear after reset, including the mirror row; past it reads zero.
    task automatic test_reset_state();
        read_req(0);
        read_req(80);
        read_req(ROWS);
        read_req(ROWS + 1);
        read_req(255);
    endtask

    // Radius 0 leaves a single pixel span on the center row only.
    task automatic test_zero_radius();
        draw_req(100, 50, 0);
        read_req(50);
        read_req(49);
    endtask

    // Circles hanging over the left and right screen edges.
    task automatic test_edge_clamp();
        draw_req(5, 80, 30);
        read_req(80);
        read_req(60);
        draw_req(235, 80, 30);
        read_req(80);
    endtask

    // Center above the screen: only some rows get written; row 160 mirrors row 0.
    task automatic test_offscreen_rows();
        draw_req(120, -10, 20);
        read_req(0);
        read_req(9);
        read_req(ROWS);
    endtask

    // Field extremes: most negative center, most positive center with max radius,
    // and a max radius circle covering the whole screen.
    task automatic test_field_extremes();
        draw_req(-512, -512, 0);
        read_req(0);
        draw_req(511, 511, 511);
        read_req(ROWS - 1);
        read_req(0);
        draw_req(120, 80, 511);
        read_req(80);
        read_req(ROWS);
    endtask

    // ---------------------------------------------------------------- random tests

    // One frame: usually a draw, then a burst of reads, half of them aimed at the circle.
    task automatic run_frame();
        int n;
        int p;
        int t;
        if ($urandom_range(99) < 90) begin
            frame_cx = ($urandom_range(99) < 80) ? int'($urandom_range(300)) - 30
                                                 : int'($urandom_range(1023)) - 512;
            frame_cy = ($urandom_range(99) < 80) ? int'($urandom_range(220)) - 30
                                                 : int'($urandom_range(1023)) - 512;
            p = $urandom_range(99);
            if (p < 70)      frame_r = $urandom_range(40);
            else if (p < 95) frame_r = $urandom_range(160, 41);
            else             frame_r = $urandom_range(511);
            draw_req(frame_cx, frame_cy, frame_r);
            // back-to-back draw: the second one must fully replace the first
            if ($urandom_range(99) < 5) begin
                frame_r = $urandom_range(60);
                draw_req(frame_cx, frame_cy, frame_r);
            end
        end
        n = $urandom_range(8, 1);
        repeat (n) begin
            p = $urandom_range(99);
            if (p < 50) begin
                t = frame_cy + int'($urandom_range(2 * frame_r + 4)) - frame_r - 2;
                if (t < 0 || t > 255) t = $urandom_range(ROWS);
            end else if (p < 80) begin
                t = $urandom_range(ROWS);
            end else if (p < 90) begin
                t = $urandom_range(1) ? ROWS : 0;
            end else begin
                t = $urandom_range(255, ROWS + 1);
            end
            read_req(t);
        end
    endtask

    task automatic test_random_frames(input int upto);
        int f;
        f = 0;
        while (sent_count < upto) begin
            if (f == 0 || $urandom_range(19) == 0) pause_for_results();
            run_frame();
            f++;
        end
    endtask

    // Same traffic with no idle cycles and no stalls on either side.
    task automatic test_steady_stream(input int upto);
        idle_pct = 0;
        while (sent_count < upto) run_frame();
        idle_pct = 11;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_zero_radius();
        test_edge_clamp();
        test_offscreen_rows();
        test_field_extremes();
        test_random_frames(ITEM_TARGET - STEADY_ITEMS);
        test_steady_stream(ITEM_TARGET);
        i_valid <= 1'b0;

        // Drain, then leave room for a trailing draw to finish.
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("circular_window_line_table_tb passed");
        end else begin
            $display("circular_window_line_table_tb failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cwlt_pkg.sv
rtl/cwlt_ram.sv
rtl/cwlt_seq.sv
rtl/circular_window_line_table.sv
verif/circular_window_line_table_tb.sv
